// ===== rtl/core/fixed_q16_divide_saturating_unit_defines.svh =====
// Assertion helpers for the 16.16 divider.
`ifndef FIXED_Q16_DIVIDE_SATURATING_UNIT_DEFINES_SVH
`define FIXED_Q16_DIVIDE_SATURATING_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FQDIV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FQDIV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fqdiv_pkg.sv =====
`default_nettype none

package fqdiv_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned GUARD_SHIFT = 14;
  localparam int unsigned STEPS       = DATA_W;
  localparam int unsigned CNT_W       = $clog2(STEPS);

  localparam logic [DATA_W-1:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_SAT = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture operand magnitudes and sign
    logic init;   // seed remainder, latch overflow guard
    logic step;   // one restoring quotient bit
    logic store;  // write the result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic guard;  // quotient magnitude would reach 2^30 or divisor is zero
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/fqdiv_dpath.sv =====
`default_nettype none

module fqdiv_dpath (
  input  wire logic                           clk_i,
  input  wire fqdiv_pkg::cmd_t                cmd_i,
  input  wire logic [fqdiv_pkg::DATA_W-1:0]   dividend_i,
  input  wire logic [fqdiv_pkg::DATA_W-1:0]   divisor_i,
  output fqdiv_pkg::sts_t                     sts_o,
  output logic      [fqdiv_pkg::DATA_W-1:0]   quotient_o,
  output logic                                saturated_o
);

  localparam int unsigned W  = fqdiv_pkg::DATA_W;
  localparam int unsigned FB = fqdiv_pkg::FRAC_BITS;

  logic [W-1:0] a_mag_q, b_mag_q;
  logic         unlike_q;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] num_q, num_d;
  logic         sat_q;
  logic [W-1:0] quot_q, quot_d;
  logic         out_sat_q;

  logic [W-1:0] a_abs, b_abs;
  logic         guard;
  logic [W:0]   rem_ext;
  logic [W:0]   diff;
  logic         geq;
  logic [W-1:0] q_neg;

  assign a_abs = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign b_abs = divisor_i[W-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  assign guard = (a_mag_q >> fqdiv_pkg::GUARD_SHIFT) >= b_mag_q;
  assign sts_o.guard = guard;

  // Restoring step: shift in the next numerator bit, subtract if it fits.
  assign rem_ext = {rem_q, num_q[W-1]};
  assign diff    = rem_ext - {1'b0, b_mag_q};
  assign geq     = rem_ext >= {1'b0, b_mag_q};

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    if (cmd_i.init) begin
      // Upper part of |a| << 16 is below |b| once the guard has passed.
      rem_d = {{FB{1'b0}}, a_mag_q[W-1:FB]};
      num_d = {a_mag_q[FB-1:0], {FB{1'b0}}};
    end else if (cmd_i.step) begin
      rem_d = geq ? diff[W-1:0] : rem_ext[W-1:0];
      num_d = {num_q[W-2:0], geq};
    end
  end

  assign q_neg = ~num_q + 1'b1;

  always_comb begin
    if (sat_q) begin
      quot_d = unlike_q ? fqdiv_pkg::NEG_SAT : fqdiv_pkg::POS_SAT;
    end else begin
      quot_d = unlike_q ? q_neg : num_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_mag_q  <= a_abs;
      b_mag_q  <= b_abs;
      unlike_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end
    if (cmd_i.init) begin
      sat_q <= guard;
    end
    rem_q <= rem_d;
    num_q <= num_d;
    if (cmd_i.store) begin
      quot_q    <= quot_d;
      out_sat_q <= sat_q;
    end
  end

  assign quotient_o  = quot_q;
  assign saturated_o = out_sat_q;

endmodule

`default_nettype wire

// ===== rtl/core/fqdiv_ctrl.sv =====
`default_nettype none

module fqdiv_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire fqdiv_pkg::sts_t sts_i,
  output fqdiv_pkg::cmd_t      cmd_o
);

  localparam int unsigned CW = fqdiv_pkg::CNT_W;
  localparam logic [CW-1:0] LAST = CW'(fqdiv_pkg::STEPS - 1);

  fqdiv_pkg::state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              oval_q, oval_d;
  logic              out_free;

  assign out_free = !oval_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqdiv_pkg::ST_IDLE;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    oval_d     = oval_q && !out_ready_i;
    case (state_q)
      fqdiv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fqdiv_pkg::ST_CHECK;
        end
      end
      fqdiv_pkg::ST_CHECK: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        // Skip the iterations on overflow or a zero divisor.
        state_d    = sts_i.guard ? fqdiv_pkg::ST_FINISH : fqdiv_pkg::ST_CALC;
      end
      fqdiv_pkg::ST_CALC: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = fqdiv_pkg::ST_FINISH;
        end
      end
      fqdiv_pkg::ST_FINISH: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd_o.store = 1'b1;
          oval_d      = 1'b1;
          state_d     = fqdiv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fqdiv_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = oval_q;

endmodule

`default_nettype wire

// ===== rtl/core/fixed_q16_divide_saturating_unit.sv =====
// Channel   Dir  Beat fields (tdata low bit up)          tuser
// s_axis    in   dividend[31:0], divisor[63:32]          -
// m_axis    out  quotient[31:0]                          saturated
//
// An item passes from accept to result register by taking magnitudes, testing
// the overflow guard, 32 restoring-division steps (one quotient bit per
// cycle) and writing the result, which waits until the output register is
// free. A saturated item skips the 32 steps.
// A new beat can be accepted in the cycle after the result is written, while that
// result may still wait in the output register. Reset is async, active low.
`default_nettype none

`include "fixed_q16_divide_saturating_unit_defines.svh"

module fixed_q16_divide_saturating_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // dividend[31:0], divisor[63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // quotient[31:0]
  output logic             m_axis_tuser    // saturated
);

  localparam int unsigned W = fqdiv_pkg::DATA_W;

  fqdiv_pkg::cmd_t cmd;
  fqdiv_pkg::sts_t sts;

  fqdiv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fqdiv_dpath u_dpath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .dividend_i (s_axis_tdata[W-1:0]),
    .divisor_i  (s_axis_tdata[2*W-1:W]),
    .sts_o      (sts),
    .quotient_o (m_axis_tdata),
    .saturated_o(m_axis_tuser)
  );

  `FQDIV_ASSERT_NOW(a_sat_value, m_axis_tvalid && m_axis_tuser, m_axis_tdata == fqdiv_pkg::POS_SAT || m_axis_tdata == fqdiv_pkg::NEG_SAT, "saturated beat carries a non-saturated value")
  `FQDIV_ASSERT_NOW(a_norm_range, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != fqdiv_pkg::NEG_SAT, "normal quotient out of range")
  `FQDIV_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a beat while dividing")

endmodule

`default_nettype wire

// ===== bench/fixed_q16_divide_saturating_unit_tb.sv =====
`timescale 1ns / 100ps

module fixed_q16_divide_saturating_unit_tb;

  localparam int unsigned DATA_W       = fqdiv_pkg::DATA_W;
  localparam int unsigned FRAC_BITS    = fqdiv_pkg::FRAC_BITS;
  localparam int unsigned GUARD_SHIFT  = fqdiv_pkg::GUARD_SHIFT;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 1025;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] quotient;
    logic              saturated;
  } div_expect_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;   // dividend[31:0], divisor[63:32]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // quotient[31:0]
  logic              m_axis_tuser;        // saturated

  logic [63:0]       pending_q[$];
  div_expect_t       quot_expect_q[$];
  int unsigned       err_cnt = 0;
  int unsigned       n_sent = 0;
  int unsigned       src_gap = 0;
  int unsigned       src_calm = 0;
  int unsigned       sink_gap = 0;
  int unsigned       sink_calm = 0;
  int unsigned       hold_left = 0;
  logic              hold_done = 1'b0;

  fixed_q16_divide_saturating_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Signed 16.16 divide on magnitudes, saturating when the guard trips.
  function automatic div_expect_t divide_q16(logic [DATA_W-1:0] num,
                                             logic [DATA_W-1:0] den);
    logic [DATA_W-1:0]           num_mag;
    logic [DATA_W-1:0]           den_mag;
    logic [DATA_W+FRAC_BITS-1:0] quo_wide;
    logic                        opposite;
    div_expect_t                 res;
    num_mag  = num[DATA_W-1] ? -num : num;
    den_mag  = den[DATA_W-1] ? -den : den;
    opposite = num[DATA_W-1] ^ den[DATA_W-1];
    res.dividend = num;
    res.divisor  = den;
    if ((num_mag >> GUARD_SHIFT) >= den_mag) begin
      res.quotient  = opposite ? fqdiv_pkg::NEG_SAT : fqdiv_pkg::POS_SAT;
      res.saturated = 1'b1;
    end else begin
      quo_wide      = {num_mag, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, den_mag};
      res.quotient  = opposite ? -quo_wide[DATA_W-1:0] : quo_wide[DATA_W-1:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] with_sign(logic [DATA_W-1:0] mag, int unsigned neg);
    return (neg != 0) ? -mag : mag;
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  // Mix of full-range, guard-boundary, small and extreme operands.
  function automatic logic [63:0] random_operands();
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] mag;
    num = $urandom;
    den = $urandom;
    case ($urandom_range(0, 9))
      3, 4: begin
        mag = $urandom >> $urandom_range(0, 31);
        num = with_sign(mag, $urandom_range(0, 1));
        mag = (mag >> GUARD_SHIFT) + DATA_W'($urandom_range(0, 3)) - 1;
        den = with_sign(mag, $urandom_range(0, 1));
      end
      5, 6: begin
        num = with_sign($urandom_range(0, 1 << 20), $urandom_range(0, 1));
        den = with_sign($urandom_range(0, 1 << 18), $urandom_range(0, 1));
      end
      7: den = with_sign($urandom_range(0, 255), $urandom_range(0, 1));
      8: begin
        num = with_sign($urandom >> $urandom_range(1, 31), $urandom_range(0, 1));
        den = with_sign($urandom >> $urandom_range(1, 31), $urandom_range(0, 1));
      end
      9: begin
        if ($urandom_range(0, 1)) num = pick_extreme();
        else den = pick_extreme();
      end
      default: ;
    endcase
    return {den, num};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", what);
  endtask

  // Driver: present queued operands, record the expectation on each accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        quot_expect_q.push_back(divide_q16(s_axis_tdata[31:0], s_axis_tdata[63:32]));
        n_sent <= n_sent + 1;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (src_gap != 0 || pending_q.size() == 0) begin
          if (src_gap != 0) src_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tdata  <= pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (src_calm != 0) begin
            src_calm--;
            src_gap = 0;
          end else begin
            src_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 80);
          end
        end
      end
    end
  end

  // Long receiver hold-off once, so the block backs up and stalls its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_sent >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation, drive tready.
  always @(posedge clk_i) begin
    div_expect_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (quot_expect_q.size() == 0) begin
          log_mismatch($sformatf("unexpected beat quotient=%h saturated=%b",
                                 m_axis_tdata, m_axis_tuser));
        end else begin
          want = quot_expect_q.pop_front();
          if (m_axis_tdata !== want.quotient || m_axis_tuser !== want.saturated)
            log_mismatch($sformatf(
              "%h / %h: expected quotient=%h saturated=%b, got quotient=%h saturated=%b",
              want.dividend, want.divisor, want.quotient, want.saturated,
              m_axis_tdata, m_axis_tuser));
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && (m_axis_tvalid || $urandom_range(0, 15) == 0)) begin
        if (sink_calm != 0) begin
          sink_calm--;
          sink_gap = 0;
        end else begin
          sink_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(20, 80);
        end
        m_axis_tready <= (sink_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    // zero by zero, signed zero divisors, unity and sign combinations
    pending_q.push_back({32'h0000_0000, 32'h0000_0000});
    pending_q.push_back({32'h0000_0000, 32'hFFFF_0000});
    pending_q.push_back({32'h0000_0000, 32'h0001_0000});
    pending_q.push_back({32'h0000_0001, 32'h0000_0000});
    pending_q.push_back({32'h0001_0000, 32'h0001_0000});
    pending_q.push_back({32'h0001_0000, 32'hFFFF_0000});
    pending_q.push_back({32'hFFFF_0000, 32'h0001_0000});
    pending_q.push_back({32'hFFFF_0000, 32'hFFFF_0000});
    // most negative and most positive operands
    pending_q.push_back({32'h8000_0000, 32'h8000_0000});
    pending_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_q.push_back({32'hFFFF_FFFF, 32'h8000_0000});
    pending_q.push_back({32'h0000_0001, 32'h8000_0000});
    pending_q.push_back({32'h8000_0000, 32'h7FFF_FFFF});
    pending_q.push_back({32'h7FFF_FFFF, 32'h8000_0000});
    pending_q.push_back({32'h7FFF_FFFF, 32'h0000_0001});
    pending_q.push_back({32'h7FFF_FFFF, 32'hFFFF_FFFF});
    // guard boundary: equal saturates, one above divides to the largest quotient
    pending_q.push_back({32'h0001_FFFF, 32'h7FFF_FFFF});
    pending_q.push_back({32'h0002_0000, 32'h7FFF_FFFF});
    pending_q.push_back({32'hFFFE_0000, 32'h7FFF_FFFF});
    pending_q.push_back({32'h0002_0000, 32'h8000_0000});
    // negative quotients, then a large dividend over the smallest divisor
    pending_q.push_back({32'h0000_0003, 32'hFFFF_FFFF});
    pending_q.push_back({32'h0003_0000, 32'hFFFF_0000});
    pending_q.push_back({32'hFFFD_0000, 32'h0001_0000});
    pending_q.push_back({32'h7FFF_FFFF, 32'h0000_0001});
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) pending_q.push_back(random_operands());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || s_axis_tvalid || quot_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && quot_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
